/* rtl/core/huffman_page_decoder_top_macros.svh */
// Assertion macros for the Huffman page decoder.
// Included by every RTL file that carries assertions; no other dependencies.
`ifndef HUFFMAN_PAGE_DECODER_TOP_MACROS_SVH
`define HUFFMAN_PAGE_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/hpd_pkg.sv */
// Shared types and constants for the Huffman page decoder.
// No dependencies; used by the top, hpd_front and hpd_back.
`default_nettype none

package hpd_pkg;

    localparam logic       OP_LOAD        = 1'b0;
    localparam logic       OP_DATA        = 1'b1;
    localparam logic       REG_ROOT_NODE  = 1'b0;
    localparam logic       REG_LEAF_LIMIT = 1'b1;
    localparam logic [7:0] ROOT_RESET     = 8'd0;
    localparam logic [7:0] LEAF_RESET     = 8'd128;
    localparam logic [9:0] POS_MAX        = 10'd1023;
    localparam logic [2:0] LAST_BIT       = 3'd7;
    localparam logic [1:0] QUEUE_DEPTH    = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] node_index;
        logic [7:0] left_child;
        logic [7:0] right_child;
        logic [7:0] data_byte;
        logic       first_of_page;
        logic [2:0] start_offset;
        logic       last_of_page;
    } t_in_word;

    typedef struct packed {
        logic [7:0] symbol;
        logic [9:0] symbol_position;
        logic       end_of_page;
    } t_out_word;

    typedef enum logic {KIND_LOAD, KIND_BYTE} t_item_kind;

    typedef struct packed {
        t_item_kind kind;
        t_in_word   word;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        logic [7:0] root_node;
        logic [7:0] leaf_limit;
    } t_cfg;

    typedef enum logic {ST_IDLE, ST_WALK} t_back_state;

endpackage

`default_nettype wire

/* rtl/core/huffman_page_decoder_top.sv */
// Huffman page decoder top: config registers, input queue, tree walker.
// o_out_valid comes from a result register. A byte word is walked bit by bit
// (one node-table fetch when it is taken, then one read per later bit); a load
// word is written from idle, and a stalled output halts the walk.
// Reset (synchronous, active low): root 0, leaf limit 128, page open, queue empty.
`default_nettype none

module huffman_page_decoder_top #(
    parameter int NODE_COUNT = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  hpd_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output hpd_pkg::t_out_word       o_out_word,
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_index,
    input  wire  [7:0]               i_cfg_data
);

    hpd_pkg::t_cfg        r_cfg;
    hpd_pkg::t_queue_head head;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.root_node  <= hpd_pkg::ROOT_RESET;
            r_cfg.leaf_limit <= hpd_pkg::LEAF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hpd_pkg::REG_ROOT_NODE:  r_cfg.root_node  <= i_cfg_data;
                hpd_pkg::REG_LEAF_LIMIT: r_cfg.leaf_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    hpd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

/* rtl/core/hpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/hpd_front.sv */
// Input side: accepts words, tags them load or byte, two-entry queue.
// Depends on hpd_pkg and the assertion macro header.
`default_nettype none

`include "huffman_page_decoder_top_macros.svh"

module hpd_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  hpd_pkg::t_in_word  i_in_word,
    output hpd_pkg::t_queue_head     o_head,
    input  wire                      i_pop
);

    hpd_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           push;
    hpd_pkg::t_item item;

    always_comb begin
        item.word = i_in_word;
        unique case (i_in_word.opcode)
            hpd_pkg::OP_LOAD: item.kind = hpd_pkg::KIND_LOAD;
            hpd_pkg::OP_DATA: item.kind = hpd_pkg::KIND_BYTE;
            default:          item.kind = hpd_pkg::KIND_LOAD;
        endcase
    end

    assign o_in_stall   = (r_count == hpd_pkg::QUEUE_DEPTH);
    assign push         = i_in_valid && !o_in_stall;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= 2'(r_count + {1'b0, push} - {1'b0, i_pop});
        end
    end

    `HPD_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0)
    `HPD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= hpd_pkg::QUEUE_DEPTH)
    `HPD_ASSERT_NXT(a_push_counts, i_clk, i_rst_n, push && !i_pop, r_count == $past(r_count) + 2'd1)

endmodule

`default_nettype wire

/* rtl/core/hpd_back.sv */
// Execution side: node table writes and the bit-by-bit tree walk, result register.
// Depends on hpd_pkg, hpd_ram and the assertion macro header.
`default_nettype none

`include "huffman_page_decoder_top_macros.svh"

module hpd_back #(
    parameter int NODE_COUNT = 256
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  hpd_pkg::t_cfg       i_cfg,
    input  wire  hpd_pkg::t_queue_head i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output hpd_pkg::t_out_word        o_out_word
);

    localparam int         AW = $clog2(NODE_COUNT);
    localparam logic [8:0] NC = 9'(NODE_COUNT);

    hpd_pkg::t_back_state r_state, n_state;
    logic [7:0]  r_walk, n_walk;
    logic [9:0]  r_pos, n_pos;
    logic        r_done, n_done;
    logic        r_open, n_open;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_rd_oor;
    logic        r_out_valid;
    hpd_pkg::t_out_word r_out;

    logic        out_free;
    logic        wr_en, rd_en;
    logic [15:0] rd_data;
    logic [7:0]  child;
    logic        bit_val, done_now, is_leaf, finish, step, emit, start;
    logic        rd_oor;
    hpd_pkg::t_out_word emit_word;
    hpd_pkg::t_in_word  hw;

    assign hw       = i_head.item.word;
    assign out_free = !r_out_valid || !i_out_stall;
    assign bit_val  = r_byte[3'(hpd_pkg::LAST_BIT - r_bit)];
    assign child    = r_rd_oor ? 8'd0 : (bit_val ? rd_data[7:0] : rd_data[15:8]);
    assign done_now = r_done || (r_bit == hpd_pkg::LAST_BIT && r_last);
    assign is_leaf  = child < i_cfg.leaf_limit;
    assign finish   = (is_leaf && done_now) || (r_bit == hpd_pkg::LAST_BIT);
    assign step     = (r_state == hpd_pkg::ST_WALK) && out_free;
    assign emit     = step && is_leaf;
    assign start    = (r_state == hpd_pkg::ST_IDLE) && i_head.valid
                      && (i_head.item.kind == hpd_pkg::KIND_BYTE)
                      && (hw.first_of_page || r_open);
    assign rd_oor   = ({1'b0, n_walk} >= NC);
    assign wr_en    = (r_state == hpd_pkg::ST_IDLE) && i_head.valid
                      && (i_head.item.kind == hpd_pkg::KIND_LOAD)
                      && ({1'b0, hw.node_index} < NC);
    assign rd_en    = start || (step && !finish);

    assign emit_word.symbol          = child;
    assign emit_word.symbol_position = r_pos;
    assign emit_word.end_of_page     = done_now;

    hpd_ram #(
        .WIDTH (16),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (hw.node_index[AW-1:0]),
        .i_wr_data ({hw.left_child, hw.right_child}),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_walk[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpd_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = hpd_pkg::ST_WALK;
                end
            end
            hpd_pkg::ST_WALK: begin
                if (step && finish) begin
                    n_state = hpd_pkg::ST_IDLE;
                end
            end
            default: n_state = hpd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_walk = r_walk;
        n_pos  = r_pos;
        n_done = r_done;
        n_open = r_open;
        n_bit  = r_bit;
        n_byte = r_byte;
        n_last = r_last;
        o_pop  = 1'b0;
        unique case (r_state)
            hpd_pkg::ST_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid && i_head.item.kind == hpd_pkg::KIND_BYTE) begin
                    n_byte = hw.data_byte;
                    n_last = hw.last_of_page;
                    n_bit  = 3'd0;
                    if (hw.first_of_page) begin
                        n_walk = i_cfg.root_node;
                        n_pos  = 10'd0;
                        n_done = 1'b0;
                        n_open = 1'b1;
                        n_bit  = hw.start_offset;
                    end
                end
            end
            hpd_pkg::ST_WALK: begin
                if (step) begin
                    n_done = done_now;
                    n_bit  = 3'(r_bit + 3'd1);
                    if (is_leaf) begin
                        n_walk = i_cfg.root_node;
                        if (r_pos != hpd_pkg::POS_MAX) begin
                            n_pos = 10'(r_pos + 10'd1);
                        end
                        if (done_now) begin
                            n_open = 1'b0;
                        end
                    end else begin
                        n_walk = child;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpd_pkg::ST_IDLE;
            r_walk      <= hpd_pkg::ROOT_RESET;
            r_pos       <= 10'd0;
            r_done      <= 1'b0;
            r_open      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_pos   <= n_pos;
            r_done  <= n_done;
            r_open  <= n_open;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit  <= n_bit;
        r_byte <= n_byte;
        r_last <= n_last;
        if (rd_en) begin
            r_rd_oor <= rd_oor;
        end
        if (emit) begin
            r_out <= emit_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `HPD_ASSERT_IMP(a_walk_open, i_clk, i_rst_n, r_state == hpd_pkg::ST_WALK, r_open)
    `HPD_ASSERT_NXT(a_eop_closes, i_clk, i_rst_n, emit && done_now, !r_open && r_state == hpd_pkg::ST_IDLE)
    `HPD_ASSERT_NXT(a_last_bit_ends, i_clk, i_rst_n, step && r_bit == hpd_pkg::LAST_BIT, r_state == hpd_pkg::ST_IDLE)
    `HPD_ASSERT_IMP(a_emit_room, i_clk, i_rst_n, emit, !r_out_valid || !i_out_stall)

endmodule

`default_nettype wire
